[rtl/gte_pkg.sv]
// shared types and constants for the graph traversal engine
package gte_pkg;

   localparam int NODE_BITS  = 4;
   localparam int WORK_DEPTH = 16;
   localparam int WL_W       = 4;
   localparam int PTR_W      = 5;

   localparam logic       CMD_EDGE      = 1'b0;
   localparam logic       CMD_TRAVERSE  = 1'b1;

   localparam logic [1:0] MODE_BFS      = 2'd0;
   localparam logic [1:0] MODE_STACK    = 2'd1;

   localparam logic       KIND_ACK      = 1'b0;
   localparam logic       KIND_VISIT    = 1'b1;

   typedef struct packed {
      logic                 valid;
      logic                 kind;
      logic [NODE_BITS-1:0] node;
      logic                 full;
      logic                 last;
   } rsp_push_type;

endpackage

[rtl/gte_ram.sv]
// generic single-write, single-read ram with registered read data
module gte_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/gte_core.sv]
// sequencer, adjacency bookkeeping and walk state of the graph traversal engine
module gte_core #(
   parameter int NODES      = 16,
   parameter int MAX_DEGREE = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_cmd,
   input  logic [gte_pkg::NODE_BITS-1:0]  req_node_a,
   input  logic [gte_pkg::NODE_BITS-1:0]  req_node_b,
   input  logic [1:0]                     req_mode,
   input  logic                           out_free,
   output gte_pkg::rsp_push_type          rsp_push
);

   localparam int NW     = gte_pkg::NODE_BITS;
   localparam int WL_W   = gte_pkg::WL_W;
   localparam int PTR_W  = gte_pkg::PTR_W;
   localparam int WDEPTH = gte_pkg::WORK_DEPTH;
   localparam int NODE_W = $clog2(NODES);
   localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
   localparam int SLOTS  = NODES * MAX_DEGREE;
   localparam int ADDR_W = $clog2(SLOTS);

   typedef enum logic [10:0] {
      ST_IDLE    = 11'b000_0000_0001,
      ST_EDGE_A  = 11'b000_0000_0010,
      ST_EDGE_B  = 11'b000_0000_0100,
      ST_EDGE_WR = 11'b000_0000_1000,
      ST_INIT    = 11'b000_0001_0000,
      ST_POP     = 11'b000_0010_0000,
      ST_SCAN    = 11'b000_0100_0000,
      ST_CHECK   = 11'b000_1000_0000,
      ST_PTOP    = 11'b001_0000_0000,
      ST_PCHK    = 11'b010_0000_0000,
      ST_FLUSH   = 11'b100_0000_0000
   } state_type;

   function automatic logic [NODE_W-1:0] to_idx(input logic [NW-1:0] v);
      to_idx = NODE_W'(v);
   endfunction

   function automatic logic node_ok(input logic [NW-1:0] v);
      node_ok = (int'(v) < NODES);
   endfunction

   function automatic logic [ADDR_W-1:0] slot(input logic [NODE_W-1:0] n,
                                              input logic [DEG_W-1:0]  k);
      slot = ADDR_W'(n) * ADDR_W'(MAX_DEGREE) + ADDR_W'(k);
   endfunction

   state_type         state_ff, state_in;
   logic [NW-1:0]     a_ff, a_in;
   logic [NW-1:0]     b_ff, b_in;
   logic              lifo_ff, lifo_in;
   logic              pre_ff, pre_in;
   logic [DEG_W-1:0]  dega_ff, dega_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [NODE_W-1:0] cur_ff, cur_in;
   logic [DEG_W-1:0]  degcur_ff, degcur_in;
   logic [DEG_W-1:0]  k_ff, k_in;
   logic              pend_valid_ff, pend_valid_in;
   logic              pend_kind_ff, pend_kind_in;
   logic [NW-1:0]     pend_node_ff, pend_node_in;
   logic              pend_full_ff, pend_full_in;

   logic [DEG_W-1:0]  deg_ff  [NODES];
   logic              vis_ff  [NODES];
   logic [NW-1:0]     work_ff [WDEPTH];
   logic [DEG_W-1:0]  nni_ff  [WDEPTH];

   // single write port per table
   logic              deg_we;
   logic [NODE_W-1:0] deg_widx;
   logic [DEG_W-1:0]  deg_wdata;
   logic              vis_clear;
   logic              vis_set;
   logic [NODE_W-1:0] vis_sidx;
   logic              work_we;
   logic [WL_W-1:0]   work_widx;
   logic [NW-1:0]     work_wdata;
   logic              nni_we;
   logic [WL_W-1:0]   nni_widx;
   logic [DEG_W-1:0]  nni_wdata;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [NW-1:0]     ram_wdata;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic [NW-1:0]     ram_rdata;

   logic [PTR_W-1:0]  tail_m1;
   logic [WL_W-1:0]   work_raddr;
   logic [NW-1:0]     work_rd;
   logic [NODE_W-1:0] cur_idx;
   logic [DEG_W-1:0]  nni_rd;
   logic [NODE_W-1:0] deg_raddr;
   logic [DEG_W-1:0]  deg_rd;
   logic              x_ok;
   logic              x_new;
   logic              can_emit;
   logic              edge_ok;
   logic              tail_room;

   gte_ram #(
      .WIDTH (NW),
      .DEPTH (SLOTS)
   ) u_nbr_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // one read address per table, picked by state
   always_comb begin
      tail_m1 = tail_ff - PTR_W'(1);
      case (state_ff)
         ST_POP: begin
            work_raddr = lifo_ff ? tail_m1[WL_W-1:0] : head_ff[WL_W-1:0];
         end
         default: begin
            work_raddr = tail_m1[WL_W-1:0];
         end
      endcase
      work_rd = work_ff[work_raddr];
      cur_idx = to_idx(work_rd);
      nni_rd  = nni_ff[tail_m1[WL_W-1:0]];
      case (state_ff)
         ST_EDGE_A: begin
            deg_raddr = to_idx(a_ff);
         end
         ST_EDGE_B, ST_EDGE_WR: begin
            deg_raddr = to_idx(b_ff);
         end
         default: begin
            deg_raddr = cur_idx;
         end
      endcase
      deg_rd    = deg_ff[deg_raddr];
      tail_room = (tail_ff < PTR_W'(WDEPTH));
      x_ok      = node_ok(ram_rdata);
      x_new     = x_ok ? (!vis_ff[to_idx(ram_rdata)] && tail_room) : 1'b0;
      can_emit  = !pend_valid_ff || out_free;
      if (node_ok(a_ff) && node_ok(b_ff)) begin
         if (a_ff == b_ff) begin
            edge_ok = (int'(dega_ff) + 2 <= MAX_DEGREE);
         end else begin
            edge_ok = (int'(dega_ff) < MAX_DEGREE) && (int'(deg_rd) < MAX_DEGREE);
         end
      end else begin
         edge_ok = 1'b0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      lifo_in       = lifo_ff;
      pre_in        = pre_ff;
      dega_in       = dega_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      cur_in        = cur_ff;
      degcur_in     = degcur_ff;
      k_in          = k_ff;
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_node_in  = pend_node_ff;
      pend_full_in  = pend_full_ff;

      deg_we     = 1'b0;
      deg_widx   = deg_raddr;
      deg_wdata  = DEG_W'(deg_rd + DEG_W'(1));
      vis_clear  = 1'b0;
      vis_set    = 1'b0;
      vis_sidx   = to_idx(ram_rdata);
      work_we    = 1'b0;
      work_widx  = tail_ff[WL_W-1:0];
      work_wdata = ram_rdata;
      nni_we     = 1'b0;
      nni_widx   = tail_ff[WL_W-1:0];
      nni_wdata  = '0;
      ram_we     = 1'b0;
      ram_waddr  = slot(to_idx(a_ff), dega_ff);
      ram_wdata  = b_ff;
      ram_re     = 1'b0;
      ram_raddr  = slot(cur_ff, k_ff);

      rsp_push       = '0;
      rsp_push.kind  = pend_kind_ff;
      rsp_push.node  = pend_node_ff;
      rsp_push.full  = pend_full_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               a_in    = req_node_a;
               b_in    = req_node_b;
               lifo_in = (req_mode == gte_pkg::MODE_STACK);
               pre_in  = (req_mode != gte_pkg::MODE_STACK) && (req_mode != gte_pkg::MODE_BFS);
               if (req_cmd == gte_pkg::CMD_EDGE) begin
                  state_in = ST_EDGE_A;
               end else if (node_ok(req_node_a)) begin
                  state_in = ST_INIT;
               end else begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_EDGE_A: begin
            dega_in  = deg_rd;
            state_in = ST_EDGE_B;
         end
         ST_EDGE_B: begin
            if (edge_ok) begin
               ram_we    = 1'b1;
               deg_we    = 1'b1;
               deg_widx  = to_idx(a_ff);
               deg_wdata = DEG_W'(dega_ff + DEG_W'(1));
               state_in  = ST_EDGE_WR;
            end else begin
               pend_valid_in = 1'b1;
               pend_kind_in  = gte_pkg::KIND_ACK;
               pend_node_in  = '0;
               pend_full_in  = 1'b1;
               state_in      = ST_FLUSH;
            end
         end
         ST_EDGE_WR: begin
            // degree of b is re-read so a self loop lands in the next slot
            ram_we        = 1'b1;
            ram_waddr     = slot(to_idx(b_ff), deg_rd);
            ram_wdata     = a_ff;
            deg_we        = 1'b1;
            pend_valid_in = 1'b1;
            pend_kind_in  = gte_pkg::KIND_ACK;
            pend_node_in  = '0;
            pend_full_in  = 1'b0;
            state_in      = ST_FLUSH;
         end
         ST_INIT: begin
            vis_clear  = 1'b1;
            vis_set    = 1'b1;
            vis_sidx   = to_idx(a_ff);
            work_we    = 1'b1;
            work_widx  = '0;
            work_wdata = a_ff;
            nni_we     = 1'b1;
            nni_widx   = '0;
            head_in    = '0;
            tail_in    = PTR_W'(1);
            if (pre_ff) begin
               pend_valid_in = 1'b1;
               pend_kind_in  = gte_pkg::KIND_VISIT;
               pend_node_in  = a_ff;
               pend_full_in  = 1'b0;
               state_in      = ST_PTOP;
            end else begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            if (head_ff == tail_ff) begin
               state_in = ST_FLUSH;
            end else if (can_emit) begin
               rsp_push.valid = pend_valid_ff;
               pend_valid_in  = 1'b1;
               pend_kind_in   = gte_pkg::KIND_VISIT;
               pend_node_in   = work_rd;
               pend_full_in   = 1'b0;
               if (lifo_ff) begin
                  tail_in = tail_m1;
               end else begin
                  head_in = head_ff + PTR_W'(1);
               end
               cur_in    = cur_idx;
               degcur_in = deg_rd;
               k_in      = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (k_ff < degcur_ff) begin
               ram_re   = 1'b1;
               k_in     = DEG_W'(k_ff + DEG_W'(1));
               state_in = ST_CHECK;
            end else begin
               state_in = ST_POP;
            end
         end
         ST_CHECK: begin
            if (x_new) begin
               vis_set = 1'b1;
               work_we = 1'b1;
               tail_in = tail_ff + PTR_W'(1);
            end
            state_in = ST_SCAN;
         end
         ST_PTOP: begin
            if (tail_ff == '0) begin
               state_in = ST_FLUSH;
            end else if (nni_rd < deg_rd) begin
               ram_re    = 1'b1;
               ram_raddr = slot(cur_idx, nni_rd);
               nni_we    = 1'b1;
               nni_widx  = tail_m1[WL_W-1:0];
               nni_wdata = DEG_W'(nni_rd + DEG_W'(1));
               state_in  = ST_PCHK;
            end else begin
               tail_in = tail_m1;
            end
         end
         ST_PCHK: begin
            if (!x_new) begin
               state_in = ST_PTOP;
            end else if (can_emit) begin
               // read data holds while the report waits for room
               rsp_push.valid = pend_valid_ff;
               pend_valid_in  = 1'b1;
               pend_kind_in   = gte_pkg::KIND_VISIT;
               pend_node_in   = ram_rdata;
               pend_full_in   = 1'b0;
               vis_set        = 1'b1;
               work_we        = 1'b1;
               nni_we         = 1'b1;
               tail_in        = tail_ff + PTR_W'(1);
               state_in       = ST_PTOP;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_push.valid = 1'b1;
               rsp_push.last  = 1'b1;
               pend_valid_in  = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         head_ff       <= '0;
         tail_ff       <= '0;
         for (int i = 0; i < NODES; i++) begin
            deg_ff[i] <= '0;
            vis_ff[i] <= 1'b0;
         end
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         if (deg_we) begin
            deg_ff[deg_widx] <= deg_wdata;
         end
         // the start node is marked in the same cycle the others are cleared
         for (int i = 0; i < NODES; i++) begin
            if (vis_set && (vis_sidx == NODE_W'(i))) begin
               vis_ff[i] <= 1'b1;
            end else if (vis_clear) begin
               vis_ff[i] <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      b_ff         <= b_in;
      lifo_ff      <= lifo_in;
      pre_ff       <= pre_in;
      dega_ff      <= dega_in;
      cur_ff       <= cur_in;
      degcur_ff    <= degcur_in;
      k_ff         <= k_in;
      pend_kind_ff <= pend_kind_in;
      pend_node_ff <= pend_node_in;
      pend_full_ff <= pend_full_in;
      if (work_we) begin
         work_ff[work_widx] <= work_wdata;
      end
      if (nni_we) begin
         nni_ff[nni_widx] <= nni_wdata;
      end
   end

endmodule

[rtl/graph_traversal_engine_top.sv]
// top level of the graph traversal engine: request port, result register, checks
//
// Keeps an undirected graph as per-node neighbor lists and walks it.
// req_* channel (valid/ready): cmd 0 appends node_a and node_b to each
// other's lists and answers with one acknowledge item (list_full set when
// a list has no room or an end is out of range). cmd 1 walks from node_a:
// mode 0 breadth first, mode 1 stack marking on push, modes 2 and 3
// recursive preorder. Each visited node comes out as one rsp_* item, in
// visiting order, with rsp_last on the final one; a bad start node gives
// no items. req_ready is high only while no item is in work.
// An edge steps through EDGE_A and EDGE_B (and EDGE_WR when it fits),
// then FLUSH sends its acknowledge. The neighbor list ram has a registered
// read port, so each neighbor entry read is a read state (SCAN or PTOP)
// followed by a check state (CHECK or PCHK).
// Reset clears the degree counts, visited marks and the sequencer; the
// neighbor ram holds no reset state. A stalled rsp_ready holds the result
// register and, once one more report is buffered, pauses the walk.
module graph_traversal_engine_top #(
   parameter int NODES      = 16,
   parameter int MAX_DEGREE = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_cmd,
   input  logic [3:0] req_node_a,
   input  logic [3:0] req_node_b,
   input  logic [1:0] req_mode,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_kind,
   output logic [3:0] rsp_node,
   output logic       rsp_list_full,
   output logic       rsp_last
);

   gte_pkg::rsp_push_type rsp_push;
   logic                  out_free;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_kind_ff;
   logic [3:0] rsp_node_ff;
   logic       rsp_full_ff;
   logic       rsp_last_ff;

   gte_core #(
      .NODES      (NODES),
      .MAX_DEGREE (MAX_DEGREE)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_cmd    (req_cmd),
      .req_node_a (req_node_a),
      .req_node_b (req_node_b),
      .req_mode   (req_mode),
      .out_free   (out_free),
      .rsp_push   (rsp_push)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_push.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push.valid) begin
         rsp_kind_ff <= rsp_push.kind;
         rsp_node_ff <= rsp_push.node;
         rsp_full_ff <= rsp_push.full;
         rsp_last_ff <= rsp_push.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_node      = rsp_node_ff;
   assign rsp_list_full = rsp_full_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // the core only loads the result register when it is empty or draining
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push.valid |-> (!rsp_valid_ff || rsp_ready))
      else $error("result pushed over a held item");

   // an accepted item always leaves the block busy in the following cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready came back right after an accepted item");

   // an edge acknowledge is the only result of its item and carries no node
   a_ack_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == gte_pkg::KIND_ACK)) |-> (rsp_last && (rsp_node == 4'd0)))
      else $error("malformed edge acknowledge");

   // visit reports never carry the dropped-edge flag
   a_visit_no_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == gte_pkg::KIND_VISIT)) |-> !rsp_list_full)
      else $error("visit report flagged as dropped edge");
`endif

endmodule
